/* hw/rtl/tmwf_pkg.sv */
// Shared constants, types and the controller state encoding for the trimmed mean filter.
`timescale 1ns / 1ps
package tmwf_pkg;

  localparam int WINDOW    = 15;
  localparam int DIVISOR   = WINDOW - 2;
  localparam int SAMPLE_W  = 16;
  localparam int CHANNELS  = 3;
  localparam int DATA_W    = SAMPLE_W * CHANNELS;
  localparam int ADDR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Running sum of the whole window, signed.
  localparam int ACC_W     = $clog2(WINDOW * 32768 + 1) + 1;
  // Magnitude of the trimmed sum.
  localparam int MAG_W     = $clog2(DIVISOR * 32768 + 1);

  // Round-up reciprocal: exact floor division for every magnitude below 2**MAG_W.
  localparam int RECIP_SHIFT = MAG_W + $clog2(DIVISOR);
  localparam int RECIP       = ((2 ** RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int PROD_W      = RECIP_SHIFT + SAMPLE_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_TRIM,
    ST_MUL,
    ST_OUT
  } tmwf_state_e;

  typedef struct packed {
    logic acc;    // read data of one window entry is present
    logic first;  // that entry is the first of the scan
    logic trim;   // form the trimmed sum and its magnitude
    logic mul;    // multiply by the reciprocal
  } lane_ctl_t;

endpackage

/* hw/rtl/tmwf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module tmwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/tmwf_lane.sv */
// One channel: accumulates sum, maximum and minimum over the window, trims them off, then divides.
`timescale 1ns / 1ps
module tmwf_lane (
  input  logic                              clk_i,
  input  tmwf_pkg::lane_ctl_t               ctl_i,
  input  logic signed [tmwf_pkg::SAMPLE_W-1:0] entry_i,
  output logic signed [tmwf_pkg::SAMPLE_W-1:0] result_o
);
  import tmwf_pkg::*;

  logic signed [ACC_W-1:0]    sum_q, sum_d;
  logic signed [SAMPLE_W-1:0] hi_q, hi_d, lo_q, lo_d;
  logic signed [ACC_W-1:0]    trim;
  logic [MAG_W-1:0]           mag_q;
  logic                       neg_q, neg2_q;
  logic [PROD_W-1:0]          prod_q;
  logic [SAMPLE_W-1:0]        quot;

  always_comb begin
    sum_d = sum_q;
    hi_d  = hi_q;
    lo_d  = lo_q;
    if (ctl_i.acc) begin
      if (ctl_i.first) begin
        sum_d = ACC_W'(entry_i);
        hi_d  = entry_i;
        lo_d  = entry_i;
      end else begin
        sum_d = sum_q + ACC_W'(entry_i);
        if (entry_i > hi_q) begin
          hi_d = entry_i;
        end
        if (entry_i < lo_q) begin
          lo_d = entry_i;
        end
      end
    end
  end

  // The trimmed sum always fits, so wrap in the intermediate difference is harmless.
  assign trim = sum_q - ACC_W'(hi_q) - ACC_W'(lo_q);

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
    if (ctl_i.trim) begin
      neg_q <= trim[ACC_W-1];
      mag_q <= MAG_W'(trim[ACC_W-1] ? -trim : trim);
    end
    if (ctl_i.mul) begin
      neg2_q <= neg_q;
      prod_q <= PROD_W'(mag_q) * PROD_W'(RECIP);
    end
  end

  // Truncation toward zero: divide the magnitude, then restore the sign.
  assign quot     = prod_q[RECIP_SHIFT +: SAMPLE_W];
  assign result_o = neg2_q ? -quot : quot;

endmodule

/* hw/rtl/trimmed_mean_window_filter.sv */
// Trimmed mean window filter: sample in, one trimmed window mean per channel out.
// Each transaction runs the states scan, drain, trim, multiply and output in order;
// the scan reads the window through the single read port of the sample RAM, and a
// new transaction is taken only back in idle, so a stalled output holds the filter.
// Reset: control state and the per-entry valid bits clear at once, so every
// window entry reads as zero until written; no clearing pass is needed.
`timescale 1ns / 1ps
module trimmed_mean_window_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // roll_in [15:0], pitch_in [31:16], yaw_in [47:32]
  input  logic [tmwf_pkg::DATA_W-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // roll_out [15:0], pitch_out [31:16], yaw_out [47:32]
  output logic [tmwf_pkg::DATA_W-1:0]   m_axis_tdata
);
  import tmwf_pkg::*;

  tmwf_state_e         state_q, state_d;
  logic [ADDR_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic [ADDR_W-1:0]   slot_q, slot_d;
  logic [WINDOW-1:0]   valid_q, valid_d;
  logic                rd_vld_q, rd_first_q, ent_vld_q;
  logic                out_vld_q, out_vld_d;
  logic [DATA_W-1:0]   out_data_q;
  logic                accept, rd_en, load;
  lane_ctl_t           ctl;
  logic [DATA_W-1:0]   ram_rdata;
  logic [DATA_W-1:0]   entry;
  logic [DATA_W-1:0]   result;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_SCAN;
      ST_SCAN:  if (rd_cnt_q == ADDR_W'(WINDOW - 1)) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_TRIM;
      ST_TRIM:  state_d = ST_MUL;
      ST_MUL:   state_d = ST_OUT;
      ST_OUT:   if (load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    load          = 1'b0;
    ctl           = '0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_SCAN: rd_en = 1'b1;
      ST_TRIM: ctl.trim = 1'b1;
      ST_MUL:  ctl.mul = 1'b1;
      ST_OUT:  load = !out_vld_q || m_axis_tready;
      default: ;
    endcase
    ctl.acc   = rd_vld_q;
    ctl.first = rd_first_q;
  end

  always_comb begin
    rd_cnt_d = rd_cnt_q;
    if (rd_en) begin
      rd_cnt_d = (rd_cnt_q == ADDR_W'(WINDOW - 1)) ? '0 : rd_cnt_q + 1'b1;
    end
    slot_d  = slot_q;
    valid_d = valid_q;
    if (accept) begin
      slot_d          = (slot_q == ADDR_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
      valid_d[slot_q] = 1'b1;
    end
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_cnt_q   <= '0;
      slot_q     <= '0;
      valid_q    <= '0;
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_cnt_q   <= rd_cnt_d;
      slot_q     <= slot_d;
      valid_q    <= valid_d;
      rd_vld_q   <= rd_en;
      rd_first_q <= rd_en && (rd_cnt_q == '0);
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      ent_vld_q <= valid_q[rd_cnt_q];
    end
    if (load) begin
      out_data_q <= result;
    end
  end

  tmwf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WINDOW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (slot_q),
    .wdata_i (s_axis_tdata),
    .re_i    (rd_en),
    .raddr_i (rd_cnt_q),
    .rdata_o (ram_rdata)
  );

  // An entry never written since reset reads as zero.
  assign entry = ent_vld_q ? ram_rdata : '0;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    tmwf_lane u_lane (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .entry_i  (entry[c*SAMPLE_W +: SAMPLE_W]),
      .result_o (result[c*SAMPLE_W +: SAMPLE_W])
    );
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN) && (rd_cnt_q == '0))
    else $error("scan did not start at entry zero after a transaction");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= ADDR_W'(WINDOW - 1))
    else $error("write slot beyond window");

  a_data_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == ST_SCAN)
    else $error("read data flagged outside the scan");

  a_trim_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TRIM |-> $past(state_q) == ST_DRAIN && !rd_vld_q)
    else $error("trim step began before the last entry was accumulated");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !out_vld_q || m_axis_tready)
    else $error("result overwrote an untaken output");
`endif

endmodule
